// ----- hdl/microsecond_alarm_timer_top_macros.svh -----
// Assertion macros for the microsecond alarm timer.
// Included by microsecond_alarm_timer_top.sv; needs no other file.
`ifndef MICROSECOND_ALARM_TIMER_TOP_MACROS_SVH
`define MICROSECOND_ALARM_TIMER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Antecedent and consequent in the same cycle.
`define MAT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Consequent in the cycle after the antecedent.
`define MAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MAT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define MAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- hdl/mat_pkg.sv -----
// Shared types and constants for the microsecond alarm timer.
// No dependencies; imported by every module of the block.
package mat_pkg;

    localparam int NUM_ALARMS_DEF = 3;
    localparam int COUNT_BITS_DEF = 32;
    localparam int IN_TDATA_W     = 72;
    localparam int OUT_TDATA_W    = 72;

    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_SET      = 3'd1,
        CMD_CANCEL   = 3'd2,
        CMD_SW_START = 3'd3,
        CMD_SW_STOP  = 3'd4
    } mat_cmd_t;

    typedef struct packed {
        mat_cmd_t    cmd;
        logic [1:0]  alarm_channel;
        logic [31:0] delay_us;
        logic [31:0] alarm_parameter;
    } mat_req_t;

    typedef struct packed {
        logic        fired;
        logic [1:0]  channel;
        logic [31:0] fired_parameter;
    } mat_fire_t;

endpackage

// ----- hdl/mat_alarm_bank.sv -----
// Compare channels of the alarm timer: compare values, enables, match flags, parameters.
// Depends on mat_pkg.
module mat_alarm_bank
    import mat_pkg::*;
#(
    parameter int NUM_ALARMS = NUM_ALARMS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  mat_req_t              req,
    input  logic [COUNT_BITS-1:0] count,
    input  logic [COUNT_BITS-1:0] count_inc,
    output mat_fire_t             fire
);

    logic [COUNT_BITS-1:0] compare_reg  [NUM_ALARMS];
    logic [COUNT_BITS-1:0] compare_next [NUM_ALARMS];
    logic [31:0]           param_reg    [NUM_ALARMS];
    logic [31:0]           param_next   [NUM_ALARMS];
    logic [NUM_ALARMS-1:0] enable_reg;
    logic [NUM_ALARMS-1:0] enable_next;
    logic [NUM_ALARMS-1:0] flag_reg;
    logic [NUM_ALARMS-1:0] flag_next;
    logic [NUM_ALARMS-1:0] flag_hit;
    logic [COUNT_BITS-1:0] arm_value;
    logic                  found;

    // The delay is a signed offset from the current count.
    assign arm_value = count + COUNT_BITS'($signed(req.delay_us));

    always_comb
    begin
        compare_next = compare_reg;
        param_next   = param_reg;
        enable_next  = enable_reg;
        flag_next    = flag_reg;
        fire         = '0;
        found        = 1'b0;
        flag_hit     = '0;
        case (req.cmd)
            CMD_TICK:
            begin
                // Flags are raised on every equal channel; only the lowest
                // enabled, flagged channel is serviced.
                for (int i = 0; i < NUM_ALARMS; i++)
                begin
                    flag_hit[i]  = flag_reg[i] | (compare_reg[i] == count_inc);
                    flag_next[i] = flag_hit[i];
                    if (!found && enable_reg[i] && flag_hit[i])
                    begin
                        found                = 1'b1;
                        flag_next[i]         = 1'b0;
                        enable_next[i]       = 1'b0;
                        fire.fired           = 1'b1;
                        fire.channel         = 2'(i);
                        fire.fired_parameter = param_reg[i];
                    end
                end
            end
            CMD_SET:
            begin
                for (int i = 0; i < NUM_ALARMS; i++)
                begin
                    if (32'(req.alarm_channel) == 32'(i))
                    begin
                        compare_next[i] = arm_value;
                        param_next[i]   = req.alarm_parameter;
                        flag_next[i]    = 1'b0;
                        enable_next[i]  = 1'b1;
                    end
                end
            end
            CMD_CANCEL:
            begin
                for (int i = 0; i < NUM_ALARMS; i++)
                begin
                    if (32'(req.alarm_channel) == 32'(i))
                    begin
                        flag_next[i]   = 1'b0;
                        enable_next[i] = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= '0;
            flag_reg   <= '0;
            for (int i = 0; i < NUM_ALARMS; i++)
            begin
                compare_reg[i] <= '0;
                param_reg[i]   <= '0;
            end
        end
        else if (en)
        begin
            enable_reg  <= enable_next;
            flag_reg    <= flag_next;
            compare_reg <= compare_next;
            param_reg   <= param_next;
        end
    end

endmodule

// ----- hdl/mat_stopwatch.sv -----
// Stopwatch of the alarm timer: latches the count on start, gives elapsed count.
// Depends on mat_pkg.
module mat_stopwatch
    import mat_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  mat_cmd_t              cmd,
    input  logic [COUNT_BITS-1:0] count,
    output logic [31:0]           elapsed_us
);

    logic [COUNT_BITS-1:0] start_reg;
    logic [COUNT_BITS-1:0] diff;

    // Difference wraps modulo the counter width; the low 32 bits are reported.
    assign diff       = count - start_reg;
    assign elapsed_us = 32'(diff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
        end
        else if (en && (cmd == CMD_SW_START))
        begin
            start_reg <= count;
        end
    end

endmodule

// ----- hdl/microsecond_alarm_timer_top.sv -----
// Top level of the microsecond alarm timer: counter, channel handshakes, result register.
// Depends on mat_pkg, mat_alarm_bank, mat_stopwatch and the assertion macro header.
//
// Usage. Requests arrive on the slave stream (s_tvalid, s_tready, s_tdata, s_tuser);
// s_tuser carries the command: tick, set alarm, cancel alarm, stopwatch start or
// stopwatch stop. Every request, whatever its command, produces exactly one result
// on the master stream (m_tvalid, m_tready, m_tdata, m_tuser). A tick advances the
// free-running counter by one and may service one alarm; a stop reports the time
// since the last start. All other requests give an all-zero result.
// The result of an accepted request is registered and presented in the cycle after
// acceptance. Throughput is one request per cycle while the receiver takes results, set
// by the single pass of compare, priority pick and update logic between the state
// registers and the result register.
// When the receiver stalls, the result register holds its contents and s_tready
// drops, so no request is taken until the pending result has been consumed; a
// result taken in the same cycle frees the register for the next request.
// Reset clears the counter, every channel (disabled, no flag, zero compare value
// and parameter), the stopwatch start and the result valid flag.
`include "microsecond_alarm_timer_top_macros.svh"

module microsecond_alarm_timer_top
    import mat_pkg::*;
#(
    parameter int NUM_ALARMS = NUM_ALARMS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // From bit 0: alarm_channel[1:0], delay_us[33:2], alarm_parameter[65:34], zeros.
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // command[2:0].
    input  logic [2:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // From bit 0: fired_channel[1:0], fired_parameter[33:2], elapsed_us[65:34], zeros.
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // From bit 0: alarm_fired[0], elapsed_valid[1].
    output logic [1:0]             m_tuser
);

    logic                  accept;
    mat_req_t              req;
    mat_fire_t             fire;
    logic [31:0]           elapsed_us;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] count_inc;

    logic                  out_valid_reg;
    logic                  fired_reg;
    logic [1:0]            fired_channel_reg;
    logic [31:0]           fired_parameter_reg;
    logic                  elapsed_valid_reg;
    logic [31:0]           elapsed_us_reg;

    // A new request is taken whenever the result register is empty or being emptied.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign req.cmd             = mat_cmd_t'(s_tuser);
    assign req.alarm_channel   = s_tdata[1:0];
    assign req.delay_us        = s_tdata[33:2];
    assign req.alarm_parameter = s_tdata[65:34];

    // The counter wraps at its full width; only tick requests advance it.
    assign count_inc  = count_reg + COUNT_BITS'(1);
    assign count_next = (req.cmd == CMD_TICK) ? count_inc : count_reg;

    mat_alarm_bank #(
        .NUM_ALARMS (NUM_ALARMS),
        .COUNT_BITS (COUNT_BITS)
    ) u_alarm_bank (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (accept),
        .req       (req),
        .count     (count_reg),
        .count_inc (count_inc),
        .fire      (fire)
    );

    mat_stopwatch #(
        .COUNT_BITS (COUNT_BITS)
    ) u_stopwatch (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (accept),
        .cmd        (req.cmd),
        .count      (count_reg),
        .elapsed_us (elapsed_us)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; it is only loaded when a request is accepted.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fired_reg           <= fire.fired;
            fired_channel_reg   <= fire.channel;
            fired_parameter_reg <= fire.fired_parameter;
            elapsed_valid_reg   <= (req.cmd == CMD_SW_STOP);
            elapsed_us_reg      <= (req.cmd == CMD_SW_STOP) ? elapsed_us : 32'd0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, elapsed_us_reg, fired_parameter_reg, fired_channel_reg};
    assign m_tuser  = {elapsed_valid_reg, fired_reg};

    // An alarm result and a stopwatch result never share one item.
    `MAT_ASSERT_SAME(a_fire_or_elapsed, clk, rst_n, m_tvalid, !(m_tuser[0] && m_tuser[1]), "alarm and elapsed results in the same item")
    // A pending result that is not taken blocks the input side.
    `MAT_ASSERT_SAME(a_stall_blocks_input, clk, rst_n, m_tvalid && !m_tready, !s_tready, "request accepted while the result register is full")
    // An accepted tick advances the counter by exactly one.
    `MAT_ASSERT_NEXT(a_tick_advances, clk, rst_n, accept && (req.cmd == CMD_TICK), count_reg == COUNT_BITS'($past(count_reg) + COUNT_BITS'(1)), "counter did not advance on a tick")

endmodule
